FILE: src/lob_pkg.sv
package lob_pkg;

   localparam int GRAY_BITS      = 8;
   localparam int CHAN_BITS      = 8;
   localparam int ALPHA_BITS     = 9;
   localparam int HIGHLIGHT_BITS = 16;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int SCRAMBLE_LEN   = 64;
   localparam int SCRAMBLE_BITS  = $clog2(SCRAMBLE_LEN);
   localparam int COLOR_COUNT    = 65;
   localparam int COLOR_BITS     = $clog2(COLOR_COUNT);

   localparam logic [ALPHA_BITS-1:0]     ALPHA_ONE       = 9'd256;
   localparam logic [ALPHA_BITS-1:0]     ALPHA_RESET     = 9'd128;
   localparam logic [HIGHLIGHT_BITS-1:0] HIGHLIGHT_RESET = 16'd0;
   localparam logic [CHAN_BITS-1:0]      WHITE           = 8'd255;

   typedef logic [CHAN_BITS-1:0] chan_type;

   typedef struct packed {
      chan_type c0;
      chan_type c1;
      chan_type c2;
   } color_type;

   typedef struct packed {
      logic [ALPHA_BITS-1:0]     alpha;
      logic [HIGHLIGHT_BITS-1:0] highlight;
   } cfg_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ALPHA     = 2'd0,
      CSR_HIGHLIGHT = 2'd1
   } csr_index_type;

   localparam logic [23:0] JET_COLORS [COLOR_COUNT] = '{
      24'h00008F, 24'h00009F, 24'h0000AF, 24'h0000BF,
      24'h0000CF, 24'h0000DF, 24'h0000EF, 24'h0000FF,
      24'h0010FF, 24'h0020FF, 24'h0030FF, 24'h0040FF,
      24'h0050FF, 24'h0060FF, 24'h0070FF, 24'h0080FF,
      24'h008FFF, 24'h009FFF, 24'h00AFFF, 24'h00BFFF,
      24'h00CFFF, 24'h00DFFF, 24'h00EFFF, 24'h00FFFF,
      24'h10FFEF, 24'h20FFDF, 24'h30FFCF, 24'h40FFBF,
      24'h50FFAF, 24'h60FF9F, 24'h70FF8F, 24'h80FF80,
      24'h8FFF70, 24'h9FFF60, 24'hAFFF50, 24'hBFFF40,
      24'hCFFF30, 24'hDFFF20, 24'hEFFF10, 24'hFFFF00,
      24'hFFEF00, 24'hFFDF00, 24'hFFCF00, 24'hFFBF00,
      24'hFFAF00, 24'hFF9F00, 24'hFF8F00, 24'hFF8000,
      24'hFF7000, 24'hFF6000, 24'hFF5000, 24'hFF4000,
      24'hFF3000, 24'hFF2000, 24'hFF1000, 24'hFF0000,
      24'hEF0000, 24'hDF0000, 24'hCF0000, 24'hBF0000,
      24'hAF0000, 24'h9F0000, 24'h8F0000, 24'h800000,
      24'h00009F
   };

   localparam logic [COLOR_BITS-1:0] SCRAMBLE [SCRAMBLE_LEN] = '{
      7'd54, 7'd6,  7'd46, 7'd17, 7'd35, 7'd63, 7'd1,  7'd23,
      7'd28, 7'd27, 7'd49, 7'd2,  7'd13, 7'd21, 7'd14, 7'd39,
      7'd30, 7'd47, 7'd45, 7'd4,  7'd26, 7'd5,  7'd57, 7'd61,
      7'd55, 7'd52, 7'd32, 7'd34, 7'd41, 7'd18, 7'd12, 7'd25,
      7'd53, 7'd56, 7'd22, 7'd19, 7'd48, 7'd9,  7'd37, 7'd8,
      7'd60, 7'd36, 7'd64, 7'd16, 7'd3,  7'd58, 7'd44, 7'd15,
      7'd7,  7'd10, 7'd20, 7'd24, 7'd40, 7'd11, 7'd43, 7'd50,
      7'd38, 7'd51, 7'd59, 7'd29, 7'd62, 7'd31, 7'd33, 7'd42
   };

   // The scramble table repeats every 64 labels, so the low six bits select the color.
   function automatic color_type color_lookup(input logic [SCRAMBLE_BITS-1:0] idx);
      color_lookup = color_type'(JET_COLORS[SCRAMBLE[idx]]);
   endfunction

endpackage

FILE: src/lob_req_if.sv
interface lob_req_if #(
   parameter int LABEL_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic [LABEL_BITS-1:0]         label;
   logic [lob_pkg::GRAY_BITS-1:0] gray;

   modport source (output valid, output label, output gray, input ready);
   modport sink   (input valid, input label, input gray, output ready);
endinterface

FILE: src/lob_rsp_if.sv
interface lob_rsp_if;
   logic              valid;
   logic              ready;
   lob_pkg::chan_type chan_zero;
   lob_pkg::chan_type chan_one;
   lob_pkg::chan_type chan_two;

   modport source (output valid, output chan_zero, output chan_one, output chan_two,
                   input ready);
   modport sink   (input valid, input chan_zero, input chan_one, input chan_two,
                   output ready);
endinterface

FILE: src/label_overlay_blend.sv
// An accepted item is held in the input register; its blended result is then
// registered in the result register, from which it can be taken.
// Throughput: one item per cycle; the input stalls only when both the input register
// and the result register hold items and the result is not being taken.
// Reset clears both valid flags, sets alpha to 128 and the highlight label to 0.
module label_overlay_blend #(
   parameter int LABEL_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   lob_req_if.sink                             req_chan,
   lob_rsp_if.source                           rsp_chan,
   input  logic                                csr_wr_en,
   input  logic [lob_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [lob_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import lob_pkg::*;

   localparam int CMP_BITS = (LABEL_BITS > HIGHLIGHT_BITS) ? LABEL_BITS : HIGHLIGHT_BITS;

   cfg_type               cfg;
   logic                  advance;
   logic                  in_valid_ff;
   logic                  in_valid_in;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   logic [LABEL_BITS-1:0] label_ff;
   logic [GRAY_BITS-1:0]  gray_ff;
   color_type             pixel;
   color_type             pixel_ff;

   lob_csr u_csr (
      .clock (clock),
      .reset (reset),
      .wr_en (csr_wr_en),
      .index (csr_index),
      .data  (csr_data),
      .cfg   (cfg)
   );

   lob_blend #(
      .LABEL_BITS (LABEL_BITS)
   ) u_blend (
      .cfg   (cfg),
      .label (label_ff),
      .gray  (gray_ff),
      .pixel (pixel)
   );

   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !in_valid_ff || advance;
   assign in_valid_in    = req_chan.ready ? req_chan.valid : in_valid_ff;
   assign out_valid_in   = advance ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         label_ff <= req_chan.label;
         gray_ff  <= req_chan.gray;
      end
      if (advance && in_valid_ff) begin
         pixel_ff <= pixel;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.chan_zero = pixel_ff.c0;
   assign rsp_chan.chan_one  = pixel_ff.c1;
   assign rsp_chan.chan_two  = pixel_ff.c2;

   a_alpha_saturated: assert property (@(posedge clock) disable iff (reset)
      cfg.alpha <= ALPHA_ONE)
      else $error("effective alpha exceeds one");

   a_result_from_input: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(in_valid_ff))
      else $error("result appeared without a held input item");

   a_highlight_white: assert property (@(posedge clock) disable iff (reset)
      (advance && in_valid_ff && (CMP_BITS'(label_ff) == CMP_BITS'(cfg.highlight)))
      |=> (pixel_ff.c0 == WHITE && pixel_ff.c1 == WHITE && pixel_ff.c2 == WHITE))
      else $error("highlighted label did not produce white");

endmodule

FILE: src/lob_csr.sv
module lob_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_en,
   input  logic [lob_pkg::CSR_INDEX_BITS-1:0]  index,
   input  logic [lob_pkg::CSR_DATA_BITS-1:0]   data,
   output lob_pkg::cfg_type                    cfg
);
   import lob_pkg::*;

   logic [ALPHA_BITS-1:0]     alpha_ff;
   logic [ALPHA_BITS-1:0]     alpha_in;
   logic [HIGHLIGHT_BITS-1:0] highlight_ff;
   logic [HIGHLIGHT_BITS-1:0] highlight_in;

   always_comb begin
      alpha_in     = alpha_ff;
      highlight_in = highlight_ff;
      if (wr_en) begin
         unique case (csr_index_type'(index))
            CSR_ALPHA: begin
               alpha_in = data[ALPHA_BITS-1:0];
            end
            CSR_HIGHLIGHT: begin
               highlight_in = data[HIGHLIGHT_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff     <= ALPHA_RESET;
         highlight_ff <= HIGHLIGHT_RESET;
      end else begin
         alpha_ff     <= alpha_in;
         highlight_ff <= highlight_in;
      end
   end

   // Weights above one saturate to one.
   assign cfg.alpha     = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;
   assign cfg.highlight = highlight_ff;

endmodule

FILE: src/lob_blend.sv
module lob_blend #(
   parameter int LABEL_BITS = 16
) (
   input  lob_pkg::cfg_type               cfg,
   input  logic [LABEL_BITS-1:0]          label,
   input  logic [lob_pkg::GRAY_BITS-1:0]  gray,
   output lob_pkg::color_type             pixel
);
   import lob_pkg::*;

   localparam int CMP_BITS = (LABEL_BITS > HIGHLIGHT_BITS) ? LABEL_BITS : HIGHLIGHT_BITS;
   localparam int PROD_BITS = ALPHA_BITS + CHAN_BITS;

   logic                  hit;
   color_type             color;
   logic [ALPHA_BITS-1:0] beta;

   function automatic chan_type blend_chan(input chan_type c,
                                           input logic [GRAY_BITS-1:0] g,
                                           input logic [ALPHA_BITS-1:0] a,
                                           input logic [ALPHA_BITS-1:0] b);
      logic [PROD_BITS-1:0] fg;
      logic [PROD_BITS-1:0] bg;
      logic [PROD_BITS-1:0] sum;
      fg  = (PROD_BITS'(a) * PROD_BITS'(c)) >> 8;
      bg  = (PROD_BITS'(b) * PROD_BITS'(g)) >> 8;
      sum = fg + bg;
      blend_chan = sum[CHAN_BITS-1:0];
   endfunction

   assign hit   = (CMP_BITS'(label) == CMP_BITS'(cfg.highlight));
   assign color = color_lookup(label[SCRAMBLE_BITS-1:0]);
   assign beta  = ALPHA_ONE - cfg.alpha;

   always_comb begin
      if (hit) begin
         pixel = '{c0: WHITE, c1: WHITE, c2: WHITE};
      end else begin
         pixel.c0 = blend_chan(color.c0, gray, cfg.alpha, beta);
         pixel.c1 = blend_chan(color.c1, gray, cfg.alpha, beta);
         pixel.c2 = blend_chan(color.c2, gray, cfg.alpha, beta);
      end
   end

endmodule
